/* hdl/ifmhd_pkg.sv */
// ----------------------------------------------------------------------------
// ifmhd_pkg
// Shared types and constants of the IF mixer and half-band decimator.
// ----------------------------------------------------------------------------
package ifmhd_pkg;

  localparam int NumTaps     = 31;
  localparam int CentreTap   = (NumTaps - 1) / 2;
  localparam int PairCount   = (CentreTap + 1) / 2;
  localparam int PhaseBitsDef = 32;
  localparam int StepW       = 32;
  localparam int IdxW        = 5;
  localparam int CoefW       = 20;
  localparam int SumW        = 22;

  typedef logic [NumTaps-1:0] win_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_LO_STEP  = 1'b0,
    CFG_COEF_SET = 1'b1
  } cfg_idx_t;

  // local oscillator tables, bit n is table entry n
  localparam logic [3:0] LoSin = 4'b0011;
  localparam logic [3:0] LoCos = 4'b1001;

  // even taps, outermost first; row 0 remez, row 1 firwin
  localparam logic signed [CoefW-1:0] SideCoef [2][PairCount] = '{
    '{-20'sd10233, 20'sd10668, -20'sd16324, 20'sd24377,
      -20'sd36482, 20'sd56990, -20'sd101993, 20'sd316926},
    '{-20'sd1888, 20'sd3862, -20'sd8242, 20'sd15947,
      -20'sd28677, 20'sd50719, -20'sd98016, 20'sd315942}
  };

  localparam logic signed [CoefW-1:0] CentreCoef [2] = '{20'sd500009, 20'sd500706};

  typedef struct packed {
    logic sample_bit;
    logic start_req;
  } in_t;

  typedef struct packed {
    logic i_sign;
    logic q_sign;
  } out_t;

endpackage

/* hdl/ifmhd_front.sv */
// ----------------------------------------------------------------------------
// ifmhd_front
// Phase accumulator, one-bit quadrature mixer, I/Q windows and decimation count.
// ----------------------------------------------------------------------------
module ifmhd_front #(
  parameter int PhaseBits = ifmhd_pkg::PhaseBitsDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  ifmhd_pkg::in_t                 in_data,
  input  logic [ifmhd_pkg::StepW-1:0]    lo_step,
  output ifmhd_pkg::win_t                i_win_next,
  output ifmhd_pkg::win_t                q_win_next,
  output logic                           emit
);
  import ifmhd_pkg::*;

  logic [PhaseBits-1:0]       phase;
  logic [PhaseBits-1:0]       phase_base;
  logic [PhaseBits-1:0]       phase_next;
  logic [PhaseBits+StepW-1:0] step_wide;
  logic [PhaseBits-1:0]       step_ext;
  win_t                       i_win;
  win_t                       q_win;
  win_t                       i_base;
  win_t                       q_base;
  logic [IdxW-1:0]            idx;
  logic [IdxW-1:0]            idx_base;
  logic [IdxW-1:0]            idx_next;
  logic                       parity;
  logic                       parity_base;
  logic [1:0]                 lo_sel;
  logic                       i_bit;
  logic                       q_bit;

  assign step_wide = {{PhaseBits{1'b0}}, lo_step};
  assign step_ext  = step_wide[PhaseBits-1:0];

  // start clears everything ahead of this sample
  always_comb begin
    if (in_data.start_req) begin
      phase_base  = '0;
      i_base      = '0;
      q_base      = '0;
      idx_base    = '0;
      parity_base = 1'b0;
    end else begin
      phase_base  = phase;
      i_base      = i_win;
      q_base      = q_win;
      idx_base    = idx;
      parity_base = parity;
    end
  end

  assign lo_sel     = phase_base[PhaseBits-1 -: 2];
  assign i_bit      = in_data.sample_bit ^ LoSin[lo_sel];
  assign q_bit      = in_data.sample_bit ^ LoCos[lo_sel];
  assign i_win_next = {i_base[NumTaps-2:0], i_bit};
  assign q_win_next = {q_base[NumTaps-2:0], q_bit};
  assign phase_next = phase_base + step_ext;
  assign idx_next   = (idx_base == '1) ? idx_base : idx_base + IdxW'(1);
  assign emit       = (idx_base >= IdxW'(NumTaps - 1)) && !parity_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      i_win  <= '0;
      q_win  <= '0;
      idx    <= '0;
      parity <= 1'b0;
    end else if (accept) begin
      phase  <= phase_next;
      i_win  <= i_win_next;
      q_win  <= q_win_next;
      idx    <= idx_next;
      parity <= ~parity_base;
    end
  end

endmodule

/* hdl/ifmhd_fir.sv */
// ----------------------------------------------------------------------------
// ifmhd_fir
// Half-band sum over one bit window (+coef for 1, -coef for 0), sign out.
// ----------------------------------------------------------------------------
module ifmhd_fir (
  input  ifmhd_pkg::win_t win,
  input  logic            coef_set,
  output logic            sign_pos
);
  import ifmhd_pkg::*;

  logic signed [SumW-1:0] pair [PairCount];
  logic signed [SumW-1:0] lvl1 [PairCount/2];
  logic signed [SumW-1:0] lvl2 [PairCount/4];
  logic signed [SumW-1:0] centre_term;
  logic signed [SumW-1:0] total;

  // symmetric taps share a coefficient: both set, both clear, or cancel
  always_comb begin
    for (int p = 0; p < PairCount; p++) begin
      case ({win[NumTaps-1-2*p], win[2*p]})
        2'b11:   pair[p] = SumW'(SideCoef[coef_set][p]) <<< 1;
        2'b00:   pair[p] = -(SumW'(SideCoef[coef_set][p]) <<< 1);
        default: pair[p] = '0;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < PairCount/2; j++) begin
      lvl1[j] = pair[2*j] + pair[2*j+1];
    end
  end

  always_comb begin
    for (int j = 0; j < PairCount/4; j++) begin
      lvl2[j] = lvl1[2*j] + lvl1[2*j+1];
    end
  end

  assign centre_term = win[CentreTap] ? SumW'(CentreCoef[coef_set])
                                      : -SumW'(CentreCoef[coef_set]);
  assign total       = lvl2[0] + lvl2[1] + centre_term;
  assign sign_pos    = ~total[SumW-1];

endmodule

/* hdl/if_mixer_halfband_decimator.sv */
// ----------------------------------------------------------------------------
// if_mixer_halfband_decimator
// One-bit quadrature mixer with a 31-tap half-band decimate-by-two FIR.
//
//   channel   direction  handshake            beat
//   in        in         in_valid / in_stall   in_data (sample_bit, start_req)
//   out       out        out_valid / out_stall out_data (i_sign, q_sign)
//   cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one sample beat per cycle while in_stall is low; a result leaves through
// the window snapshot register and then the output register.
// rst is synchronous and clears phase, windows, counters, valid flags and config.
// a stalled output holds its beat; the snapshot stage still takes one more
// result-bearing sample, and only then does in_stall rise.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module if_mixer_halfband_decimator #(
  parameter int PhaseBits = ifmhd_pkg::PhaseBitsDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ifmhd_pkg::in_t              in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ifmhd_pkg::out_t             out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [ifmhd_pkg::StepW-1:0] cfg_data
);
  import ifmhd_pkg::*;

  logic [StepW-1:0] lo_step;
  logic             coef_set;
  logic             accept;
  logic             emit;
  logic             s1_adv;
  logic             s1_valid;
  win_t             i_win_next;
  win_t             q_win_next;
  win_t             s1_i_win;
  win_t             s1_q_win;
  logic             i_pos;
  logic             q_pos;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_step  <= '0;
      coef_set <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LO_STEP:  lo_step  <= cfg_data;
        CFG_COEF_SET: coef_set <= cfg_data[0];
        default:      lo_step  <= lo_step;
      endcase
    end
  end

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  ifmhd_front #(
    .PhaseBits (PhaseBits)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_data    (in_data),
    .lo_step    (lo_step),
    .i_win_next (i_win_next),
    .q_win_next (q_win_next),
    .emit       (emit)
  );

  // window snapshot for a result-bearing sample
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_i_win <= i_win_next;
      s1_q_win <= q_win_next;
    end
  end

  ifmhd_fir u_fir_i (
    .win      (s1_i_win),
    .coef_set (coef_set),
    .sign_pos (i_pos)
  );

  ifmhd_fir u_fir_q (
    .win      (s1_q_win),
    .coef_set (coef_set),
    .sign_pos (q_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_data.i_sign <= i_pos;
      out_data.q_sign <= q_pos;
    end
  end

endmodule

/* verif/if_mixer_halfband_decimator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// if_mixer_halfband_decimator_tb
// Self-checking bench for the one-bit IF mixer and half-band decimator.
// A short table of sample beats exercises start, window fill, odd positions
// and the all-ones and all-zeros windows. Random capture streams follow under
// several phase steps and both coefficient sets; the first four add random
// gaps on the sample side and stall on the result side. Every result beat is
// checked against a cycle-free model of the mixer, windows and FIR signs.
// ----------------------------------------------------------------------------
module if_mixer_halfband_decimator_tb;
  import ifmhd_pkg::*;

  localparam int SettingCount = 7;
  localparam int BeatsPerSetting = 72;

  // even taps outermost first, then centre; remez row, firwin row
  localparam int SideTaps [2][8] = '{
    '{-10233, 10668, -16324, 24377, -36482, 56990, -101993, 316926},
    '{-1888, 3862, -8242, 15947, -28677, 50719, -98016, 315942}
  };
  localparam int CentreTaps [2] = '{500009, 500706};
  localparam logic [3:0] SinBits = 4'b0011;
  localparam logic [3:0] CosBits = 4'b1001;

  typedef struct {
    in_t  beat;
    int   reps;
    bit   typed;
    out_t want;
  } probe_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_LO_STEP;
  logic [31:0] cfg_data = '0;

  // model state
  logic [31:0] nco_phase = '0;
  logic [31:0] nco_step = '0;
  logic        coef_col = 1'b0;
  logic [30:0] i_taps = '0;
  logic [30:0] q_taps = '0;
  int          taps_seen = 0;
  bit          odd_pos = 1'b0;

  out_t sign_pairs_due [$];
  out_t oldest_due;
  int   send_idle_pct = 26;
  int   rx_idle_pct = 65;
  int   samples_sent = 0;
  int   pairs_checked = 0;
  int   sign_errors = 0;

  probe_row_t probe_rows [10] = '{
    '{'{1'b0, 1'b1}, 1,  1'b0, '{1'b0, 1'b0}},
    '{'{1'b0, 1'b0}, 29, 1'b0, '{1'b0, 1'b0}},
    '{'{1'b0, 1'b0}, 1,  1'b1, '{1'b1, 1'b1}},
    '{'{1'b0, 1'b0}, 1,  1'b0, '{1'b0, 1'b0}},
    '{'{1'b0, 1'b0}, 1,  1'b1, '{1'b1, 1'b1}},
    '{'{1'b1, 1'b0}, 31, 1'b0, '{1'b0, 1'b0}},
    '{'{1'b1, 1'b0}, 1,  1'b1, '{1'b0, 1'b0}},
    '{'{1'b1, 1'b1}, 1,  1'b0, '{1'b0, 1'b0}},
    '{'{1'b1, 1'b0}, 29, 1'b0, '{1'b0, 1'b0}},
    '{'{1'b1, 1'b0}, 1,  1'b1, '{1'b0, 1'b0}}
  };

  if_mixer_halfband_decimator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic halfband_sign(input logic [30:0] win, input logic col);
    int acc;
    int c;
    int d;
    acc = 0;
    for (int k = 0; k < 31; k++) begin
      if (k == 15) begin
        c = CentreTaps[col];
      end else if (k % 2 == 1) begin
        c = 0;
      end else begin
        d = (k < 15) ? k : 30 - k;
        c = SideTaps[col][d / 2];
      end
      acc += win[k] ? c : -c;
    end
    return acc >= 0;
  endfunction

  function automatic bit mix_and_filter(input in_t beat, output out_t pair);
    logic [1:0] quad;
    logic       ib;
    logic       qb;
    bit         emit;
    if (beat.start_req) begin
      nco_phase = '0;
      i_taps = '0;
      q_taps = '0;
      taps_seen = 0;
      odd_pos = 1'b0;
    end
    quad = nco_phase[31:30];
    ib = beat.sample_bit ^ SinBits[quad];
    qb = beat.sample_bit ^ CosBits[quad];
    i_taps = {i_taps[29:0], ib};
    q_taps = {q_taps[29:0], qb};
    emit = (taps_seen >= 30) && !odd_pos;
    pair.i_sign = halfband_sign(i_taps, coef_col);
    pair.q_sign = halfband_sign(q_taps, coef_col);
    if (taps_seen < 31) taps_seen++;
    odd_pos = !odd_pos;
    nco_phase = nco_phase + nco_step;
    return emit;
  endfunction

  task automatic send_sample(input in_t beat, input bit typed, input out_t want);
    out_t pair;
    int   gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    if (mix_and_filter(beat, pair) || typed) begin
      sign_pairs_due.push_back(typed ? want : pair);
    end
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sign_pairs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_mixer(input logic [31:0] step, input logic col);
    for (int r = 0; r < 2; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (r == 0) ? CFG_LO_STEP : CFG_COEF_SET;
      cfg_data <= (r == 0) ? step : {31'd0, col};
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    nco_step = step;
    coef_col = col;
  endtask

  task automatic flag_mismatch(input string what, input out_t want, input out_t got);
    if (sign_errors < 10) begin
      $display("%0t %s: expected i=%b q=%b, got i=%b q=%b",
               $realtime, what, want.i_sign, want.q_sign, got.i_sign, got.q_sign);
    end
    sign_errors++;
  endtask

  // result side: check accepted beats, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (sign_pairs_due.size() == 0) begin
        flag_mismatch("unexpected beat", 'x, out_data);
      end else begin
        oldest_due = sign_pairs_due.pop_front();
        if (oldest_due.i_sign !== out_data.i_sign || oldest_due.q_sign !== out_data.q_sign)
          flag_mismatch("sign mismatch", oldest_due, out_data);
      end
      pairs_checked++;
    end
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("FAIL if_mixer_halfband_decimator");
    $finish;
  end

  initial begin
    logic [31:0] steps [SettingCount];
    logic        cols [SettingCount];
    in_t         beat;
    bit          square;
    bit          lead_start;
    steps = '{32'h4000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0,
              32'h8000_0000, 32'hC000_0000, 32'h0};
    cols = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    steps[3] = $urandom;
    steps[6] = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero step, remez taps
    foreach (probe_rows[r]) begin
      for (int n = 0; n < probe_rows[r].reps; n++) begin
        send_sample(probe_rows[r].beat, probe_rows[r].typed, probe_rows[r].want);
      end
    end
    wait_drain();

    for (int s = 0; s < SettingCount; s++) begin
      if (s < 2) begin
        send_idle_pct = 26;
        rx_idle_pct = 65;
      end else if (s < 4) begin
        send_idle_pct = 65;
        rx_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        rx_idle_pct = 0;
      end
      program_mixer(steps[s], cols[s]);
      square = ($urandom_range(2) == 0);
      lead_start = ($urandom_range(9) != 0);
      for (int n = 0; n < BeatsPerSetting; n++) begin
        if (square) beat.sample_bit = n[1] ^ ($urandom_range(9) == 0);
        else beat.sample_bit = 1'($urandom_range(1));
        beat.start_req = (n == 0 && lead_start) || ($urandom_range(99) < 2);
        send_sample(beat, 1'b0, '0);
        if (s == 0 && n == 45) wait_drain();
      end
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (sign_pairs_due.size() != 0) begin
      $display("%0d expected result beats never arrived", sign_pairs_due.size());
      sign_errors++;
    end

    $display("covered %0d sample beats and %0d result beats over %0d step/tap settings",
             samples_sent, pairs_checked, SettingCount + 1);
    $display("mismatches: %0d", sign_errors);
    if (sign_errors == 0) begin
      $display("PASS if_mixer_halfband_decimator");
    end else begin
      $display("FAIL if_mixer_halfband_decimator");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/ifmhd_pkg.sv
hdl/ifmhd_front.sv
hdl/ifmhd_fir.sv
hdl/if_mixer_halfband_decimator.sv
verif/if_mixer_halfband_decimator_tb.sv
